// File: hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps

package kts_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned KEY_COUNT_W = 7;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned VAL_W       = 32;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 7'd1;

  // Operation codes carried in the opcode field.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // One input beat.
  typedef struct packed {
    logic                     opcode;
    logic [SLOT_W-1:0]        key_slot;
    logic [TIME_W-1:0]        time_value;
    logic signed [VAL_W-1:0]  in_x;
    logic signed [VAL_W-1:0]  in_y;
    logic signed [VAL_W-1:0]  in_z;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;
    logic [SLOT_W-1:0]        segment;
  } out_item_t;

  // Status that the key search hands to the sequencer and the divider.
  typedef struct packed {
    logic              done;
    logic              last;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
  } sr_status_t;

endpackage

// File: hw/rtl/keyframe_track_sampler.sv
// Keyframe write beats are accepted back to back. A sample beat goes from accept to
// result through a scan of the key time store at one entry per cycle, then, when the
// sample falls inside a segment, a one-bit-per-cycle divider, then a four-step mix in
// three component lanes. At most one sample is in flight; the next beat is taken in
// the cycle after its result is loaded, and a stalled output holds off that load.
// Reset clears control state and sets key_count to 1; the key stores are not cleared.
`timescale 1ns / 1ps

module keyframe_track_sampler #(
  parameter int unsigned MAX_KEYS      = 64,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kts_pkg::KEY_COUNT_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  kts_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output kts_pkg::out_item_t              out_data_o
);
  import kts_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_KEYS);
  localparam int unsigned NW  = $clog2(MAX_KEYS + 1);
  localparam int unsigned KCW = (NW > KEY_COUNT_W) ? NW : KEY_COUNT_W;
  localparam int unsigned SLW = (NW > SLOT_W) ? NW : SLOT_W;
  localparam int unsigned NL  = 3;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SEARCH,
    T_DIV,
    T_MIX,
    T_HOLD
  } top_state_e;

  top_state_e               state_q;
  logic [KEY_COUNT_W-1:0]   key_count_q;
  logic                     out_valid_q;
  out_item_t                out_q;
  logic                     accept, sample_accept, key_write;
  logic [KCW-1:0]           kc_ext;
  logic [NW-1:0]            n_eff;
  logic [SLW-1:0]           slot_ext, seg_ext;
  logic [AW-1:0]            wr_addr, seg;
  sr_status_t               sr;
  logic                     div_start, div_done;
  logic [FRACTION_BITS:0]   div_factor, lane_factor;
  logic                     mix_start, load;
  logic [NL-1:0]            lane_done;
  logic signed [VAL_W-1:0]  lane_res [NL];
  logic signed [VAL_W-1:0]  lane_wval [NL];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KEY_COUNT_RESET;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  // Input beat decode; writes beyond the store are dropped.
  assign in_ready_o    = state_q == T_IDLE;
  assign accept        = in_valid_i && in_ready_o;
  assign sample_accept = accept && (in_data_i.opcode == OP_SAMPLE);
  assign slot_ext      = SLW'(in_data_i.key_slot);
  assign key_write     = accept && (in_data_i.opcode == OP_WRITE) &&
                         (slot_ext < SLW'(MAX_KEYS));
  assign wr_addr       = slot_ext[AW-1:0];

  // Keys in use, limited to the range 1 .. MAX_KEYS.
  assign kc_ext = KCW'(key_count_q);
  always_comb begin
    if (kc_ext == '0) begin
      n_eff = NW'(1);
    end else if (kc_ext > KCW'(MAX_KEYS)) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = kc_ext[NW-1:0];
    end
  end

  kts_search #(
    .MAX_KEYS (MAX_KEYS),
    .AW       (AW),
    .NW       (NW)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (key_write),
    .wr_addr_i (wr_addr),
    .wr_time_i (in_data_i.time_value),
    .start_i   (sample_accept),
    .t_i       (in_data_i.time_value),
    .n_i       (n_eff),
    .status_o  (sr),
    .seg_o     (seg)
  );

  // The divider runs only when the sample falls inside a segment.
  assign div_start = (state_q == T_SEARCH) && sr.done && !sr.last;

  kts_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .t_i      (sr.t),
    .t0_i     (sr.t0),
    .t1_i     (sr.t1),
    .done_o   (div_done),
    .factor_o (div_factor)
  );

  // At or after the last key a zero factor returns the start key unchanged.
  assign mix_start   = ((state_q == T_SEARCH) && sr.done && sr.last) ||
                       ((state_q == T_DIV) && div_done);
  assign lane_factor = sr.last ? '0 : div_factor;

  assign lane_wval[0] = in_data_i.in_x;
  assign lane_wval[1] = in_data_i.in_y;
  assign lane_wval[2] = in_data_i.in_z;

  // One lane per vector component.
  for (genvar g = 0; g < NL; g++) begin : g_lane
    kts_lane #(
      .MAX_KEYS      (MAX_KEYS),
      .FRACTION_BITS (FRACTION_BITS),
      .AW            (AW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (key_write),
      .wr_addr_i (wr_addr),
      .wr_val_i  (lane_wval[g]),
      .start_i   (mix_start),
      .seg_i     (seg),
      .factor_i  (lane_factor),
      .done_o    (lane_done[g]),
      .res_o     (lane_res[g])
    );
  end

  // Merge the lane results into the output register once it is free.
  assign load = ((state_q == T_MIX && lane_done[0]) || state_q == T_HOLD) &&
                (!out_valid_q || out_ready_i);
  assign seg_ext = SLW'(seg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q   <= 1'b1;
        out_q.out_x   <= lane_res[0];
        out_q.out_y   <= lane_res[1];
        out_q.out_z   <= lane_res[2];
        out_q.segment <= seg_ext[SLOT_W-1:0];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (sample_accept) state_q <= T_SEARCH;
        end
        T_SEARCH: begin
          if (sr.done) state_q <= sr.last ? T_MIX : T_DIV;
        end
        T_DIV: begin
          if (div_done) state_q <= T_MIX;
        end
        T_MIX: begin
          if (lane_done[0]) state_q <= load ? T_IDLE : T_HOLD;
        end
        T_HOLD: begin
          if (load) state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // All lanes share one schedule and finish in the same cycle.
  a_lanes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> (lane_done[1] && lane_done[2]))
    else $error("component lanes finished out of step");

  // The search reports only while the sequencer waits for it.
  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr.done |-> (state_q == T_SEARCH))
    else $error("search result arrived outside the search phase");

  // The divider reports only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == T_DIV))
    else $error("divider result arrived outside the divide phase");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded result not presented");

  // No new beat is taken while a sample is in flight.
  a_one_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_accept |=> !in_ready_o)
    else $error("input accepted during a sample");

endmodule

// File: hw/rtl/kts_search.sv
`timescale 1ns / 1ps

module kts_search #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned AW       = $clog2(MAX_KEYS),
  parameter int unsigned NW       = $clog2(MAX_KEYS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [kts_pkg::TIME_W-1:0] wr_time_i,
  input  logic                       start_i,
  input  logic [kts_pkg::TIME_W-1:0] t_i,
  input  logic [NW-1:0]              n_i,
  output kts_pkg::sr_status_t        status_o,
  output logic [AW-1:0]              seg_o
);
  import kts_pkg::*;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_FIRST,
    SR_SCAN
  } sr_state_e;

  sr_state_e         state_q;
  logic [TIME_W-1:0] time_mem [MAX_KEYS];
  logic [TIME_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic [NW-1:0]     idx_q, idx_d;
  logic [NW-1:0]     n_q;
  logic [TIME_W-1:0] t_q, prev_q, t0_q, t1_q;
  logic [AW-1:0]     seg_q;
  logic              done_q, last_q;
  logic              hit, at_end;

  // Key time store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i] <= wr_time_i;
    end
    rd_data_q <= time_mem[rd_addr];
  end

  // The first key after key 0 whose time exceeds the sample time ends the scan.
  assign hit    = t_q < rd_data_q;
  assign at_end = (idx_q + NW'(1)) == n_q;

  // Next read address: the key read back in the following cycle.
  always_comb begin
    idx_d = idx_q;
    case (state_q)
      SR_IDLE: begin
        if (start_i) idx_d = '0;
      end
      SR_FIRST: begin
        idx_d = NW'(1);
      end
      SR_SCAN: begin
        if (!hit && !at_end) idx_d = idx_q + NW'(1);
      end
      default: idx_d = idx_q;
    endcase
  end

  assign rd_addr = idx_d[AW-1:0];

  // Scan sequencer and its registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      t_q     <= '0;
      prev_q  <= '0;
      t0_q    <= '0;
      t1_q    <= '0;
      seg_q   <= '0;
      done_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      idx_q  <= idx_d;
      case (state_q)
        SR_IDLE: begin
          if (start_i) begin
            t_q     <= t_i;
            n_q     <= n_i;
            state_q <= SR_FIRST;
          end
        end
        SR_FIRST: begin
          prev_q <= rd_data_q;
          if (n_q == NW'(1)) begin
            seg_q   <= '0;
            last_q  <= 1'b1;
            done_q  <= 1'b1;
            state_q <= SR_IDLE;
          end else begin
            state_q <= SR_SCAN;
          end
        end
        SR_SCAN: begin
          if (hit) begin
            seg_q   <= AW'(idx_q - NW'(1));
            t0_q    <= prev_q;
            t1_q    <= rd_data_q;
            last_q  <= 1'b0;
            done_q  <= 1'b1;
            state_q <= SR_IDLE;
          end else if (at_end) begin
            seg_q   <= AW'(n_q - NW'(1));
            last_q  <= 1'b1;
            done_q  <= 1'b1;
            state_q <= SR_IDLE;
          end else begin
            prev_q <= rd_data_q;
          end
        end
        default: state_q <= SR_IDLE;
      endcase
    end
  end

  assign status_o.done = done_q;
  assign status_o.last = last_q;
  assign status_o.t    = t_q;
  assign status_o.t0   = t0_q;
  assign status_o.t1   = t1_q;
  assign seg_o         = seg_q;

endmodule

// File: hw/rtl/kts_div.sv
`timescale 1ns / 1ps

module kts_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [kts_pkg::TIME_W-1:0] t_i,
  input  logic [kts_pkg::TIME_W-1:0] t0_i,
  input  logic [kts_pkg::TIME_W-1:0] t1_i,
  output logic                       done_o,
  output logic [FRACTION_BITS:0]     factor_o
);
  import kts_pkg::*;

  localparam int unsigned DW = TIME_W + 1;
  localparam int unsigned CW = $clog2(FRACTION_BITS + 1);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_PREP,
    DV_ITER
  } dv_state_e;

  dv_state_e                state_q;
  logic signed [DW-1:0]     num_q, den_q;
  logic [DW-1:0]            an, ad;
  logic [DW-1:0]            rem_q, ad_q;
  logic [DW:0]              rem_sh;
  logic                     ge;
  logic [FRACTION_BITS-1:0] quo_q, quo_d;
  logic [CW-1:0]            cnt_q;
  logic [FRACTION_BITS:0]   factor_q;
  logic                     done_q;
  logic                     opp_sign;

  // Magnitudes of numerator and denominator.
  assign an       = num_q[DW-1] ? DW'(-num_q) : DW'(num_q);
  assign ad       = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
  assign opp_sign = num_q[DW-1] != den_q[DW-1];

  // One restoring division step per cycle.
  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, ad_q};
  assign quo_d  = {quo_q[FRACTION_BITS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= DV_IDLE;
      num_q    <= '0;
      den_q    <= '0;
      rem_q    <= '0;
      ad_q     <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
      factor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            num_q   <= $signed({1'b0, t_i}) - $signed({1'b0, t0_i});
            den_q   <= $signed({1'b0, t1_i}) - $signed({1'b0, t0_i});
            state_q <= DV_PREP;
          end
        end
        DV_PREP: begin
          // Zero or negative ratios clamp to zero, ratios of one or more to one.
          if (den_q == '0 || num_q == '0 || opp_sign) begin
            factor_q <= '0;
            done_q   <= 1'b1;
            state_q  <= DV_IDLE;
          end else if (an >= ad) begin
            factor_q <= {1'b1, {FRACTION_BITS{1'b0}}};
            done_q   <= 1'b1;
            state_q  <= DV_IDLE;
          end else begin
            rem_q   <= an;
            ad_q    <= ad;
            quo_q   <= '0;
            cnt_q   <= CW'(FRACTION_BITS);
            state_q <= DV_ITER;
          end
        end
        DV_ITER: begin
          rem_q <= ge ? DW'(rem_sh - {1'b0, ad_q}) : DW'(rem_sh);
          quo_q <= quo_d;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            factor_q <= {1'b0, quo_d};
            done_q   <= 1'b1;
            state_q  <= DV_IDLE;
          end
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign factor_o = factor_q;

endmodule

// File: hw/rtl/kts_lane.sv
`timescale 1ns / 1ps

module kts_lane #(
  parameter int unsigned MAX_KEYS      = 64,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned AW            = $clog2(MAX_KEYS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic signed [kts_pkg::VAL_W-1:0]  wr_val_i,
  input  logic                              start_i,
  input  logic [AW-1:0]                     seg_i,
  input  logic [FRACTION_BITS:0]            factor_i,
  output logic                              done_o,
  output logic signed [kts_pkg::VAL_W-1:0]  res_o
);
  import kts_pkg::*;

  localparam int unsigned DW = VAL_W + 1;
  localparam int unsigned PW = DW + FRACTION_BITS + 2;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_RD0,
    LN_RD1,
    LN_MUL,
    LN_ADD
  } ln_state_e;

  ln_state_e               state_q;
  logic [VAL_W-1:0]        val_mem [MAX_KEYS];
  logic [VAL_W-1:0]        rd_data_q;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           seg_q;
  logic [FRACTION_BITS:0]  f_q;
  logic [VAL_W-1:0]        s_q;
  logic signed [DW-1:0]    d_q;
  logic signed [PW-1:0]    p_q, p_d, p_sh;
  logic [VAL_W-1:0]        res_q;
  logic                    done_q;

  // Component store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
    rd_data_q <= val_mem[rd_addr];
  end

  // Start key first, then the key after it.
  assign rd_addr = (state_q == LN_IDLE) ? seg_i : seg_q + AW'(1);

  // Product of the difference and the factor, then a floor shift.
  assign p_d  = d_q * $signed({1'b0, f_q});
  assign p_sh = p_q >>> FRACTION_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
      seg_q   <= '0;
      f_q     <= '0;
      s_q     <= '0;
      d_q     <= '0;
      p_q     <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        LN_IDLE: begin
          if (start_i) begin
            seg_q   <= seg_i;
            f_q     <= factor_i;
            state_q <= LN_RD0;
          end
        end
        LN_RD0: begin
          s_q     <= rd_data_q;
          state_q <= LN_RD1;
        end
        LN_RD1: begin
          // With a zero factor the key after the start, which may never have
          // been written, does not enter the result.
          if (f_q == '0) begin
            d_q <= '0;
          end else begin
            d_q <= $signed({rd_data_q[VAL_W-1], rd_data_q}) - $signed({s_q[VAL_W-1], s_q});
          end
          state_q <= LN_MUL;
        end
        LN_MUL: begin
          p_q     <= p_d;
          state_q <= LN_ADD;
        end
        LN_ADD: begin
          res_q   <= s_q + p_sh[VAL_W-1:0];
          done_q  <= 1'b1;
          state_q <= LN_IDLE;
        end
        default: state_q <= LN_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: test/keyframe_track_sampler_checker.sv
`timescale 1ns / 1ps

module keyframe_track_sampler_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kts_pkg::KEY_COUNT_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  kts_pkg::in_item_t               in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  kts_pkg::out_item_t              out_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import kts_pkg::*;

  localparam int unsigned TRACK_DEPTH = 64;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned REPORT_MAX  = 10;

  // Local copy of the track and of the key count register.
  logic [TIME_W-1:0]       key_time_mem [TRACK_DEPTH];
  logic signed [VAL_W-1:0] key_x_mem    [TRACK_DEPTH];
  logic signed [VAL_W-1:0] key_y_mem    [TRACK_DEPTH];
  logic signed [VAL_W-1:0] key_z_mem    [TRACK_DEPTH];
  logic [KEY_COUNT_W-1:0]  key_count_q;

  // Interpolated vectors still owed by the block, oldest first.
  out_item_t               samples_due [$];
  out_item_t               want;

  // Position of t inside [t0, t1] as an unsigned Q1.16 fraction, clamped to [0, 1].
  // A zero-length segment or a time on the wrong side of the start gives 0.
  function automatic logic [FRAC_W:0] segment_fraction(input logic [TIME_W-1:0] t,
                                                       input logic [TIME_W-1:0] t0,
                                                       input logic [TIME_W-1:0] t1);
    logic signed [TIME_W+1:0] num;
    logic signed [TIME_W+1:0] den;
    logic [TIME_W+FRAC_W:0]   quot;
    num = $signed({2'b00, t}) - $signed({2'b00, t0});
    den = $signed({2'b00, t1}) - $signed({2'b00, t0});
    if (den == 0 || num == 0 || num[TIME_W+1] != den[TIME_W+1]) return '0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    quot = {num[TIME_W:0], {FRAC_W{1'b0}}} / den[TIME_W:0];
    if (quot > {1'b1, {FRAC_W{1'b0}}}) return {1'b1, {FRAC_W{1'b0}}};
    return quot[FRAC_W:0];
  endfunction

  // start + f * (end - start), with the product floored back to Q16.16.
  function automatic logic signed [VAL_W-1:0] lerp_lane(input logic signed [VAL_W-1:0] s,
                                                        input logic signed [VAL_W-1:0] e,
                                                        input logic [FRAC_W:0] f);
    logic signed [VAL_W:0]          span;
    logic signed [VAL_W+FRAC_W+1:0] prod;
    span = $signed({e[VAL_W-1], e}) - $signed({s[VAL_W-1], s});
    prod = span * $signed({1'b0, f});
    prod = prod >>> FRAC_W;
    return s + prod[VAL_W-1:0];
  endfunction

  // Segment search followed by per-component interpolation.
  function automatic out_item_t sample_track(input logic [TIME_W-1:0] t);
    int unsigned     n;
    int unsigned     seg;
    logic [FRAC_W:0] f;
    out_item_t       res;
    n = key_count_q;
    if (n == 0) n = 1;
    if (n > TRACK_DEPTH) n = TRACK_DEPTH;
    seg = n - 1;
    for (int unsigned i = 0; i + 1 < n && seg == n - 1; i++) begin
      if (t < key_time_mem[i + 1]) seg = i;
    end
    if (seg == n - 1) begin
      res.out_x = key_x_mem[seg];
      res.out_y = key_y_mem[seg];
      res.out_z = key_z_mem[seg];
    end else begin
      f = segment_fraction(t, key_time_mem[seg], key_time_mem[seg + 1]);
      res.out_x = lerp_lane(key_x_mem[seg], key_x_mem[seg + 1], f);
      res.out_y = lerp_lane(key_y_mem[seg], key_y_mem[seg + 1], f);
      res.out_z = lerp_lane(key_z_mem[seg], key_z_mem[seg + 1], f);
    end
    res.segment = seg[SLOT_W-1:0];
    return res;
  endfunction

  task automatic report_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= REPORT_MAX) $display("%0t ns: %s", $time, what);
  endtask

  // Track register and key writes, queue a prediction per sample beat, and
  // compare every result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q = KEY_COUNT_RESET;
      samples_due.delete();
    end else begin
      if (cfg_we_i) key_count_q = cfg_wdata_i;

      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OP_WRITE) begin
          key_time_mem[in_data_i.key_slot] = in_data_i.time_value;
          key_x_mem[in_data_i.key_slot]    = in_data_i.in_x;
          key_y_mem[in_data_i.key_slot]    = in_data_i.in_y;
          key_z_mem[in_data_i.key_slot]    = in_data_i.in_z;
        end else begin
          samples_due.push_back(sample_track(in_data_i.time_value));
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (samples_due.size() == 0) begin
          report_failure($sformatf("unexpected result beat: x=%h y=%h z=%h seg=%0d",
                                   out_data_i.out_x, out_data_i.out_y, out_data_i.out_z,
                                   out_data_i.segment));
        end else begin
          want = samples_due.pop_front();
          checked_o++;
          if (out_data_i.out_x !== want.out_x || out_data_i.out_y !== want.out_y ||
              out_data_i.out_z !== want.out_z || out_data_i.segment !== want.segment) begin
            report_failure($sformatf(
              "result mismatch: expected x=%h y=%h z=%h seg=%0d, got x=%h y=%h z=%h seg=%0d",
              want.out_x, want.out_y, want.out_z, want.segment,
              out_data_i.out_x, out_data_i.out_y, out_data_i.out_z, out_data_i.segment));
          end
        end
      end
    end
    pending_o = samples_due.size();
  end

endmodule

// File: test/keyframe_track_sampler_test.sv
`timescale 1ns / 1ps

module keyframe_track_sampler_test;
  import kts_pkg::*;

  localparam int unsigned KEY_SLOTS      = 64;
  localparam int unsigned MAX_GAP        = 13;
  localparam int unsigned SETTLE_CYCLES  = 100;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET    = 400;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [KEY_COUNT_W-1:0] cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping: key times last written, used to aim sample times.
  logic [TIME_W-1:0] key_times [KEY_SLOTS];
  logic              steady_flow  = 1'b0;
  logic              hold_request = 1'b0;
  int                write_count   = 0;
  int                sample_count  = 0;
  int                setting_count = 0;
  int                quiet         = 0;

  always #5 clk = ~clk;

  keyframe_track_sampler u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  keyframe_track_sampler_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int slots_in_use(input logic [KEY_COUNT_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > KEY_SLOTS) return KEY_SLOTS;
    return int'(setting);
  endfunction

  function automatic logic [VAL_W-1:0] pick_component();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // Sample times land on keys, next to keys, inside the track, at the
  // ends of the time range, or anywhere.
  function automatic logic [TIME_W-1:0] pick_sample_time(input int n);
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] on_key;
    lo = key_times[0];
    hi = key_times[n-1];
    if (hi < lo) begin
      on_key = lo;
      lo = hi;
      hi = on_key;
    end
    on_key = key_times[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 9))
      0, 1: return on_key;
      2: return $urandom_range(0, 1) ? on_key + 1 : on_key - 1;
      7: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      8, 9: return $urandom;
      default: return lo + $urandom_range(0, hi - lo);
    endcase
  endfunction

  // Offer one beat after a random gap and hold it until accepted. Returns at
  // the falling edge after the accept with valid still high, so the next
  // call either replaces the beat or drops valid in that same step.
  task automatic send_beat(input in_item_t beat);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] t,
                           input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                           input logic [VAL_W-1:0] z);
    in_item_t beat;
    beat.opcode     = OP_WRITE;
    beat.key_slot   = slot;
    beat.time_value = t;
    beat.in_x       = x;
    beat.in_y       = y;
    beat.in_z       = z;
    key_times[slot] = t;
    send_beat(beat);
    write_count++;
  endtask

  // Slot and vector fields are don't-care on a sample; fill them with noise.
  task automatic sample_at(input logic [TIME_W-1:0] t);
    in_item_t beat;
    beat.opcode     = OP_SAMPLE;
    beat.key_slot   = SLOT_W'($urandom_range(0, KEY_SLOTS - 1));
    beat.time_value = t;
    beat.in_x       = $urandom;
    beat.in_y       = $urandom;
    beat.in_z       = $urandom;
    send_beat(beat);
    sample_count++;
  endtask

  // The register only changes once the block has drained and gone quiet.
  task automatic set_key_count(input logic [KEY_COUNT_W-1:0] setting);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= setting;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    setting_count++;
  endtask

  // Write keys 0..n-1: mostly ascending times, sometimes with repeated
  // times (zero-length segments), sometimes in no order at all.
  task automatic load_track(input int n);
    int                shape;
    logic [TIME_W-1:0] t;
    shape = $urandom_range(0, 9);
    t = $urandom_range(0, 32'h0100_0000);
    for (int k = 0; k < n; k++) begin
      if (shape == 9) begin
        t = $urandom;
      end else if (k > 0 && !(shape == 8 && $urandom_range(0, 2) == 0)) begin
        t = t + $urandom_range(1, 32'h0004_0000);
      end
      write_key(SLOT_W'(k), t, pick_component(), pick_component(), pick_component());
    end
  endtask

  // One random phase: new key count, fresh track, then mostly samples with
  // the odd stray key rewrite. A squeeze phase stalls the output side for a
  // long stretch while samples keep coming.
  task automatic run_phase(input logic [KEY_COUNT_W-1:0] setting, input bit squeeze);
    int n;
    int ops;
    n = slots_in_use(setting);
    set_key_count(setting);
    steady_flow = squeeze || ($urandom_range(0, 3) == 0);
    load_track(n);
    if (squeeze) hold_request = 1'b1;
    ops = $urandom_range(4, 12);
    repeat (ops) begin
      if (!squeeze && $urandom_range(0, 6) == 0) begin
        write_key(SLOT_W'($urandom_range(0, KEY_SLOTS - 1)), $urandom,
                  pick_component(), pick_component(), pick_component());
      end else begin
        sample_at(pick_sample_time(n));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int                     phase;
    logic [KEY_COUNT_W-1:0] setting;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single key at the reset key count: the key's vector comes back as is.
    write_key(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);

    // One segment spanning the whole time range and the whole value range.
    set_key_count(2);
    write_key(0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    write_key(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    sample_at(32'h0);
    sample_at(32'h8000_0000);
    sample_at(32'hFFFF_FFFE);
    sample_at(32'hFFFF_FFFF);

    // A zero-length first segment, a middle segment and the last key.
    set_key_count(3);
    write_key(0, 32'd1000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
    write_key(1, 32'd1000, 32'h0005_0000, 32'h8000_0000, 32'hEDCB_A988);
    write_key(2, 32'd2000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h0000_0003);
    sample_at(32'd500);
    sample_at(32'd1500);
    sample_at(32'd2000);

    // Keys out of order clamp the factor to one; a time before the start clamps it to zero.
    set_key_count(2);
    write_key(0, 32'd3000, 32'h0010_0000, 32'h8000_0001, 32'h7FFF_FFFE);
    sample_at(32'd500);
    write_key(1, 32'd5000, 32'hFFF0_0000, 32'h0000_0000, 32'h8000_0000);
    sample_at(32'd1000);

    // A key count of zero behaves like one.
    set_key_count(0);
    sample_at(32'd12345);

    // Random phases: full and oversized tracks first, then mostly short ones.
    phase = 0;
    while (write_count + sample_count < ITEM_TARGET) begin
      case (phase)
        0: setting = 127;
        1: setting = 64;
        2: setting = 1;
        3: setting = 2;
        default: begin
          case ($urandom_range(0, 9))
            0: setting = 64;
            1: setting = KEY_COUNT_W'($urandom_range(0, 127));
            2, 3: setting = KEY_COUNT_W'($urandom_range(9, 20));
            default: setting = KEY_COUNT_W'($urandom_range(1, 8));
          endcase
        end
      endcase
      run_phase(setting, phase == 3 || $urandom_range(0, 7) == 0);
      phase++;
    end

    // Drain, then give the block time to show any stray result.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d key writes and %0d samples (%0d results checked) over %0d",
             write_count, sample_count, checked, setting_count);
    $display("key count settings, including zero, 64, 127 and long output stalls.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls, with a long hold-off when asked for one.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: too many cycles without a beat on either channel ends the run.
  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout after %0d cycles without a beat.", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
